@@ hdl/rrts_pkg.sv @@
// Shared types and codes of the round-robin task scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_UNBLOCK  = 3'd3,
    OP_YIELD    = 3'd4,
    OP_EXIT     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_RUNNING = 3'd0,
    ST_READY   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_WAITING = 3'd3,
    ST_HANGING = 3'd4,
    ST_DIED    = 3'd5
  } status_e;

  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_NO_ID   = 2'd1;
  localparam logic [1:0] RES_INVALID = 2'd2;

  localparam logic [1:0] KIND_INVALID = 2'd3;

  localparam int unsigned BmWordBits = 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CR_RD,
    S_CR_CHK,
    S_SCHED,
    S_SC_APP,
    S_SC_RDN,
    S_SC_POP,
    S_IDLE_RD,
    S_IDLE_CHK,
    S_BL_WR,
    S_IDLE_PUSH,
    S_UB_RD,
    S_UB_CHK,
    S_EX_RD,
    S_EX_CHK,
    S_FIN,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] kind;
    logic [7:0] prio;
    logic       start;
    logic       need;
    logic       bad;
  } cmd_t;

endpackage

@@ hdl/rrts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/rrts_front.sv @@
// Front end: decodes requests and buffers them in a two-entry command queue.
`timescale 1ns / 1ps

module rrts_front #(
  parameter int MAX_TASKS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [15:0]                  id_base_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [2:0]                   opcode_i,
  input  logic [15:0]                  task_id_i,
  input  logic [7:0]                   priority_req_i,
  input  logic [1:0]                   block_kind_i,
  input  logic                         start_running_i,
  input  logic                         need_schedule_i,
  output logic                         cmd_valid_o,
  output rrts_pkg::cmd_t               cmd_o,
  output logic [$clog2(MAX_TASKS)-1:0] cmd_slot_o,
  input  logic                         cmd_pop_i
);
  import rrts_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);

  cmd_t          fifo_q [2];
  logic [SW-1:0] slot_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  logic [15:0] diff;
  logic        in_range, needs_id;
  cmd_t        dec;
  logic        wr_en, rd_en;

  always_comb begin
    diff     = task_id_i - id_base_i;
    in_range = 32'(diff) < 32'(MAX_TASKS);
    needs_id = (opcode_i == 3'(OP_UNBLOCK)) || (opcode_i == 3'(OP_EXIT));
    dec.op    = op_e'(opcode_i);
    dec.kind  = block_kind_i;
    dec.prio  = priority_req_i;
    dec.start = start_running_i;
    dec.need  = need_schedule_i;
    dec.bad   = (opcode_i > 3'(OP_EXIT)) || (needs_id && !in_range);
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign cmd_slot_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_en    = push_i && !full_o;
    rd_en    = cmd_pop_i && cmd_valid_o;
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= dec;
      slot_q[wr_ptr_q] <= SW'(diff);
    end
  end

endmodule

@@ hdl/rrts_back.sv @@
// Back end: executes scheduler commands against the task tables and ready queue.
`timescale 1ns / 1ps

module rrts_back #(
  parameter int MAX_TASKS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [15:0]                  id_base_i,
  input  logic [9:0]                   idle_task_i,
  input  logic                         cmd_valid_i,
  input  rrts_pkg::cmd_t               cmd_i,
  input  logic [$clog2(MAX_TASKS)-1:0] cmd_slot_i,
  output logic                         cmd_pop_o,
  input  logic                         res_pop_i,
  output logic                         res_valid_o,
  output logic [1:0]                   result_code_o,
  output logic [15:0]                  created_id_o,
  output logic                         switched_o,
  output logic [15:0]                  next_task_o,
  output logic [7:0]                   next_slice_o
);
  import rrts_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int NW = (MAX_TASKS + BmWordBits - 1) / BmWordBits;
  localparam int WW = (NW > 1) ? $clog2(NW) : 1;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [WW-1:0] w_q, w_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d, run_q, run_d;
  logic          run_vld_q, run_vld_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] bm_vld_q, bm_vld_d;
  logic [1:0]    code_q, code_d;
  logic [15:0]   created_q, created_d;
  logic          sw_q, sw_d;
  logic          res_vld_q, res_vld_d;
  logic [1:0]    res_code_q, res_code_d;
  logic [15:0]   res_created_q, res_created_d, res_task_q, res_task_d;
  logic          res_sw_q, res_sw_d;
  logic [7:0]    res_slice_q, res_slice_d;

  // memory ports
  logic          bm_we, st_we, pr_we, nx_we, pv_we;
  logic [WW-1:0] bm_waddr, bm_raddr;
  logic [31:0]   bm_wdata, bm_rdata;
  logic [SW-1:0] st_waddr, st_raddr, pr_waddr, pr_raddr;
  logic [SW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [2:0]    st_wdata, st_rdata;
  logic [7:0]    pr_rdata;
  logic [SW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;

  rrts_ram #(.Width(BmWordBits), .Depth(NW)) u_bm_ram (
    .clk_i, .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );
  rrts_ram #(.Width(3), .Depth(MAX_TASKS)) u_st_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );
  rrts_ram #(.Width(8), .Depth(MAX_TASKS)) u_pr_ram (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i(cmd_q.prio),
    .raddr_i(pr_raddr), .rdata_o(pr_rdata)
  );
  rrts_ram #(.Width(SW), .Depth(MAX_TASKS)) u_nx_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );
  rrts_ram #(.Width(SW), .Depth(MAX_TASKS)) u_pv_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );

  // allocator bit positions of the command slot and the idle slot
  logic [SW-1:0] idle_slot;
  logic [WW-1:0] slot_row, idle_row;
  logic [4:0]    slot_bit, idle_bit;
  logic          idle_in_range, idle_is_run;
  logic [31:0]   slot_word, idle_word, scan_word, scan_raw;
  logic [2:0]    slot_st, idle_st;
  logic          scan_found;
  logic [4:0]    scan_bit;
  logic [SW-1:0] scan_slot;

  function automatic logic is_waiting(logic [2:0] st);
    return (st == ST_BLOCKED) || (st == ST_WAITING) || (st == ST_HANGING);
  endfunction

  always_comb begin
    idle_slot     = SW'(idle_task_i);
    idle_in_range = 32'(idle_task_i) < 32'(MAX_TASKS);
    idle_is_run   = 32'(idle_task_i) == 32'(run_q);
    slot_row      = WW'(slot_q >> 5);
    slot_bit      = 5'(slot_q);
    idle_row      = WW'(idle_slot >> 5);
    idle_bit      = 5'(idle_slot);
    slot_word     = bm_vld_q[slot_row] ? bm_rdata : '0;
    idle_word     = bm_vld_q[idle_row] ? bm_rdata : '0;
    slot_st       = slot_word[slot_bit] ? st_rdata : 3'(ST_DIED);
    idle_st       = idle_word[idle_bit] ? st_rdata : 3'(ST_DIED);
    scan_raw      = bm_vld_q[w_q] ? bm_rdata : '0;
    // slots past the end of the table count as taken
    for (int b = 0; b < BmWordBits; b++) begin
      scan_word[b] = scan_raw[b] || (((32'(w_q) << 5) + 32'(b)) >= 32'(MAX_TASKS));
    end
    scan_found = 1'b0;
    scan_bit   = '0;
    for (int b = BmWordBits - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        scan_found = 1'b1;
        scan_bit   = 5'(b);
      end
    end
    scan_slot = SW'({w_q, scan_bit});
  end

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    slot_d        = slot_q;
    w_d           = w_q;
    head_d        = head_q;
    tail_d        = tail_q;
    run_d         = run_q;
    run_vld_d     = run_vld_q;
    cnt_d         = cnt_q;
    bm_vld_d      = bm_vld_q;
    code_d        = code_q;
    created_d     = created_q;
    sw_d          = sw_q;
    res_vld_d     = res_vld_q;
    res_code_d    = res_code_q;
    res_created_d = res_created_q;
    res_sw_d      = res_sw_q;
    res_task_d    = res_task_q;
    res_slice_d   = res_slice_q;
    cmd_pop_o     = 1'b0;

    bm_we    = 1'b0;
    bm_waddr = slot_row;
    bm_wdata = slot_word;
    bm_raddr = slot_row;
    st_we    = 1'b0;
    st_waddr = slot_q;
    st_wdata = 3'(ST_READY);
    st_raddr = slot_q;
    pr_we    = 1'b0;
    pr_waddr = slot_q;
    pr_raddr = run_q;
    nx_we    = 1'b0;
    nx_waddr = slot_q;
    nx_wdata = head_q;
    nx_raddr = slot_q;
    pv_we    = 1'b0;
    pv_waddr = slot_q;
    pv_wdata = tail_q;
    pv_raddr = slot_q;

    if (res_pop_i && res_vld_q) begin
      res_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_vld_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          slot_d    = cmd_slot_i;
          w_d       = '0;
          code_d    = RES_OK;
          created_d = '0;
          sw_d      = 1'b0;
          if (cmd_i.bad) begin
            code_d  = RES_INVALID;
            state_d = S_FIN;
          end else begin
            unique case (cmd_i.op)
              OP_CREATE: begin
                if (cmd_i.start && run_vld_q) begin
                  code_d  = RES_INVALID;
                  state_d = S_FIN;
                end else begin
                  state_d = S_CR_RD;
                end
              end
              OP_SCHEDULE: state_d = S_SCHED;
              OP_BLOCK: begin
                if (cmd_i.kind == KIND_INVALID || !run_vld_q) begin
                  code_d  = RES_INVALID;
                  state_d = S_FIN;
                end else if (cnt_q != '0 || idle_is_run) begin
                  state_d = S_BL_WR;
                end else begin
                  state_d = S_IDLE_RD;
                end
              end
              OP_UNBLOCK: state_d = S_UB_RD;
              OP_YIELD: begin
                if (!run_vld_q) begin
                  code_d  = RES_INVALID;
                  state_d = S_FIN;
                end else begin
                  state_d = S_SC_APP;
                end
              end
              OP_EXIT: state_d = S_EX_RD;
              default: begin
                code_d  = RES_INVALID;
                state_d = S_FIN;
              end
            endcase
          end
        end
      end

      S_CR_RD: begin
        bm_raddr = w_q;
        state_d  = S_CR_CHK;
      end

      S_CR_CHK: begin
        if (!scan_found) begin
          if (32'(w_q) == 32'(NW - 1)) begin
            code_d  = RES_NO_ID;
            state_d = S_FIN;
          end else begin
            w_d     = w_q + WW'(1);
            state_d = S_CR_RD;
          end
        end else begin
          bm_we            = 1'b1;
          bm_waddr         = w_q;
          bm_wdata         = scan_raw | (32'd1 << scan_bit);
          bm_vld_d[w_q]    = 1'b1;
          pr_we            = 1'b1;
          pr_waddr         = scan_slot;
          st_we            = 1'b1;
          st_waddr         = scan_slot;
          created_d        = 16'(scan_slot) + id_base_i;
          if (cmd_q.start) begin
            st_wdata  = 3'(ST_RUNNING);
            run_d     = scan_slot;
            run_vld_d = 1'b1;
          end else begin
            st_wdata = 3'(ST_READY);
            if (cnt_q == '0) begin
              head_d = scan_slot;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = tail_q;
              nx_wdata = scan_slot;
              pv_we    = 1'b1;
              pv_waddr = scan_slot;
              pv_wdata = tail_q;
            end
            tail_d = scan_slot;
            cnt_d  = cnt_q + CW'(1);
          end
          state_d = S_FIN;
        end
      end

      S_SCHED: begin
        if (run_vld_q) begin
          state_d = S_SC_APP;
        end else if (cnt_q != '0) begin
          state_d = S_SC_RDN;
        end else begin
          state_d = S_IDLE_RD;
        end
      end

      S_SC_APP: begin
        if (cnt_q == '0) begin
          head_d = run_q;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = tail_q;
          nx_wdata = run_q;
          pv_we    = 1'b1;
          pv_waddr = run_q;
          pv_wdata = tail_q;
        end
        tail_d   = run_q;
        cnt_d    = cnt_q + CW'(1);
        st_we    = 1'b1;
        st_waddr = run_q;
        st_wdata = 3'(ST_READY);
        state_d  = S_SC_RDN;
      end

      S_SC_RDN: begin
        nx_raddr = head_q;
        state_d  = S_SC_POP;
      end

      S_SC_POP: begin
        st_we     = 1'b1;
        st_waddr  = head_q;
        st_wdata  = 3'(ST_RUNNING);
        run_d     = head_q;
        run_vld_d = 1'b1;
        cnt_d     = cnt_q - CW'(1);
        if (cnt_q != CW'(1)) begin
          head_d = nx_rdata;
        end
        sw_d    = 1'b1;
        state_d = S_FIN;
      end

      S_IDLE_RD: begin
        st_raddr = idle_slot;
        bm_raddr = idle_row;
        state_d  = S_IDLE_CHK;
      end

      S_IDLE_CHK: begin
        if (!(idle_in_range && is_waiting(idle_st))) begin
          code_d  = RES_INVALID;
          state_d = S_FIN;
        end else if (cmd_q.op == OP_BLOCK) begin
          state_d = S_BL_WR;
        end else begin
          state_d = S_IDLE_PUSH;
        end
      end

      S_BL_WR: begin
        st_we    = 1'b1;
        st_waddr = run_q;
        st_wdata = 3'(ST_BLOCKED) + 3'(cmd_q.kind);
        state_d  = (cnt_q != '0) ? S_SC_RDN : S_IDLE_PUSH;
      end

      S_IDLE_PUSH: begin
        // queue is empty here: the idle task becomes the whole queue
        head_d   = idle_slot;
        tail_d   = idle_slot;
        cnt_d    = CW'(1);
        st_we    = 1'b1;
        st_waddr = idle_slot;
        st_wdata = 3'(ST_READY);
        state_d  = S_SC_RDN;
      end

      S_UB_RD: state_d = S_UB_CHK;

      S_UB_CHK: begin
        if (is_waiting(slot_st)) begin
          if (cnt_q == '0) begin
            tail_d = slot_q;
          end else begin
            pv_we    = 1'b1;
            pv_waddr = head_q;
            pv_wdata = slot_q;
            nx_we    = 1'b1;
            nx_waddr = slot_q;
            nx_wdata = head_q;
          end
          head_d   = slot_q;
          cnt_d    = cnt_q + CW'(1);
          st_we    = 1'b1;
          st_wdata = 3'(ST_READY);
        end else begin
          code_d = RES_INVALID;
        end
        state_d = S_FIN;
      end

      S_EX_RD: state_d = S_EX_CHK;

      S_EX_CHK: begin
        if (!slot_word[slot_bit]) begin
          code_d  = RES_INVALID;
          state_d = S_FIN;
        end else begin
          // free the id; a cleared allocator bit reads as a dead task
          bm_we              = 1'b1;
          bm_wdata           = slot_word & ~(32'd1 << slot_bit);
          bm_vld_d[slot_row] = 1'b1;
          if (run_vld_q && run_q == slot_q) begin
            run_vld_d = 1'b0;
          end
          if (st_rdata == ST_READY && cnt_q != '0) begin
            cnt_d = cnt_q - CW'(1);
            if (cnt_q != CW'(1)) begin
              if (slot_q == head_q) begin
                head_d = nx_rdata;
              end else if (slot_q == tail_q) begin
                tail_d = pv_rdata;
              end else begin
                nx_we    = 1'b1;
                nx_waddr = pv_rdata;
                nx_wdata = nx_rdata;
                pv_we    = 1'b1;
                pv_waddr = nx_rdata;
                pv_wdata = pv_rdata;
              end
            end
          end
          state_d = cmd_q.need ? S_SCHED : S_FIN;
        end
      end

      S_FIN: begin
        pr_raddr = run_q;
        state_d  = S_OUT;
      end

      S_OUT: begin
        res_vld_d     = 1'b1;
        res_code_d    = code_q;
        res_created_d = created_q;
        res_sw_d      = sw_q;
        res_task_d    = run_vld_q ? (16'(run_q) + id_base_i) : 16'd0;
        res_slice_d   = run_vld_q ? pr_rdata : 8'd0;
        state_d       = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      run_q     <= '0;
      run_vld_q <= 1'b0;
      cnt_q     <= '0;
      bm_vld_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      run_q     <= run_d;
      run_vld_q <= run_vld_d;
      cnt_q     <= cnt_d;
      bm_vld_q  <= bm_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    slot_q        <= slot_d;
    w_q           <= w_d;
    code_q        <= code_d;
    created_q     <= created_d;
    sw_q          <= sw_d;
    res_code_q    <= res_code_d;
    res_created_q <= res_created_d;
    res_sw_q      <= res_sw_d;
    res_task_q    <= res_task_d;
    res_slice_q   <= res_slice_d;
  end

  assign res_valid_o   = res_vld_q;
  assign result_code_o = res_code_q;
  assign created_id_o  = res_created_q;
  assign switched_o    = res_sw_q;
  assign next_task_o   = res_task_q;
  assign next_slice_o  = res_slice_q;

endmodule

@@ hdl/round_robin_task_scheduler.sv @@
// Top level of the round-robin task scheduler.
`timescale 1ns / 1ps

// Round-robin task scheduler. Requests (create, schedule, block, unblock,
// yield, exit) enter through a queue-style port (push/full). Each one
// produces exactly one result on a queue-style output (empty/pop), in order.
// A front end decodes each request, checks the opcode and the id range, and
// parks it in a two-entry command queue. A back end runs one command at a
// time through a sequencer over five RAMs: the id allocator bitmap (one
// 32-bit word per row), task status, task priority, and the next/prev links
// of the ready queue. Queue head, tail, count and the running task live in
// flops. Paths per request, from the back end taking it to its result:
// - create: scans the allocator words in order (lowest free id wins).
// - schedule: requeues the running task if any, then pops the queue head;
//   with no task running or queued it wakes the idle task first.
// - yield: requeues the running task, then pops the queue head.
// - block: marks the running task blocked (by kind), then pops the queue
//   head; with an empty queue it puts the idle task in it.
// - unblock: puts the task at the head of the ready queue.
// - exit: frees the id, unlinks a ready task, and may add a schedule step.
// - errors caught at decode go straight to the result.
// With the default MAX_TASKS the allocator scan, one RAM word at a time,
// sets the worst case. A finished result waits in its own register while
// the front end keeps accepting requests. There is no clearing pass after
// reset: only the rows of the allocator carry valid bits, and a slot whose
// allocator bit is clear reads as a dead task, so the status table needs no
// initialization.
// Configuration: id_base at address 0 (reset 1), idle_task at address 4
// (reset 0); write them only while no request is in flight.
module round_robin_task_scheduler #(
  parameter int MAX_TASKS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] task_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [1:0]  block_kind_i,
  input  logic        start_running_i,
  input  logic        need_schedule_i,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_code_o,
  output logic [15:0] created_id_o,
  output logic        switched_o,
  output logic [15:0] next_task_o,
  output logic [7:0]  next_slice_o
);
  import rrts_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);

  // Register index from the word address: bit 2 picks id_base or idle_task.
  localparam logic REG_ID_BASE   = 1'b0;
  localparam logic REG_IDLE_TASK = 1'b1;

  logic [15:0] id_base_q;
  logic [9:0]  idle_task_q;
  logic        cfg_wr;

  logic          cmd_valid, cmd_pop, res_valid;
  cmd_t          cmd;
  logic [SW-1:0] cmd_slot;

  // Zero-wait APB: every access completes in its access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_ID_BASE:   prdata = {16'd0, id_base_q};
      REG_IDLE_TASK: prdata = {22'd0, idle_task_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_base_q   <= 16'd1;
      idle_task_q <= 10'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ID_BASE) begin
        id_base_q <= pwdata[15:0];
      end else begin
        idle_task_q <= pwdata[9:0];
      end
    end
  end

  // Decode and buffer incoming requests.
  rrts_front #(.MAX_TASKS(MAX_TASKS)) u_front (
    .clk_i,
    .rst_ni,
    .id_base_i       (id_base_q),
    .push_i          (push),
    .full_o          (full),
    .opcode_i,
    .task_id_i,
    .priority_req_i,
    .block_kind_i,
    .start_running_i,
    .need_schedule_i,
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_slot_o      (cmd_slot),
    .cmd_pop_i       (cmd_pop)
  );

  // Execute one command at a time and hold its result until the transfer.
  rrts_back #(.MAX_TASKS(MAX_TASKS)) u_back (
    .clk_i,
    .rst_ni,
    .id_base_i     (id_base_q),
    .idle_task_i   (idle_task_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_slot_i    (cmd_slot),
    .cmd_pop_o     (cmd_pop),
    .res_pop_i     (pop),
    .res_valid_o   (res_valid),
    .result_code_o,
    .created_id_o,
    .switched_o,
    .next_task_o,
    .next_slice_o
  );

  assign empty = !res_valid;

endmodule
